// ===== hdl/linear_gradient_color_interpolator_macros.svh =====
// Assertion macros for the linear gradient color interpolator.
`ifndef LINEAR_GRADIENT_COLOR_INTERPOLATOR_MACROS_SVH
`define LINEAR_GRADIENT_COLOR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTH
// Implication checked at every clock edge outside reset.
`define LGCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also active during reset.
`define LGCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGCI_ASSERT(lbl, prop, msg)
`define LGCI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/lgci_pkg.sv =====
// Shared types and constants of the linear gradient color interpolator.
package lgci_pkg;

  localparam int CH_W        = 8;
  localparam int POS_W       = 12;
  localparam int SPAN_W      = 13;
  localparam int PROD_W      = CH_W + POS_W;
  localparam int LANES       = 4;
  localparam int MAX_SPAN_DEF = 4096;
  localparam int ADDR_W      = 4;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_SPAN  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // Lane order follows byte position in the packed color.
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;
  localparam int LANE_ALPHA = 3;

  // One channel moving through the divider chain.
  typedef struct packed {
    logic [SPAN_W-1:0] rem;   // partial remainder
    logic [PROD_W-1:0] num;   // dividend bits shifting out, quotient bits in
    logic              neg;   // end byte below start byte
    logic [CH_W-1:0]   base;  // start byte
  } lane_t;

  typedef lane_t [LANES-1:0] lanes_t;

endpackage

// ===== hdl/linear_gradient_color_interpolator.sv =====
// Top level of the linear gradient color interpolator.
// Takes one line position per cycle and returns the ABGR color at that line:
// each channel is start + (end - start) * position / span, the quotient
// truncated toward zero and the sum kept to 8 bits; a span of zero gives the
// start color and a span above MAX_SPAN is taken as MAX_SPAN. The work runs
// through one multiply stage and a row of 20 divider cells, one quotient bit
// per cell for all four channels at once, so a new position is taken every
// cycle that the chain is not stalled. A stall on the result side
// is caught by one skid entry; the input then stalls until it drains.
// Registers on the configuration port: 0x0 start color, 0x4 end color,
// 0x8 span length; write them only while no item is in flight.
`include "linear_gradient_color_interpolator_macros.svh"
module linear_gradient_color_interpolator
  import lgci_pkg::*;
#(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [11:0] position, [15:12] zero
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
);

  logic [31:0]       start_r;
  logic [31:0]       end_r;
  logic [SPAN_W-1:0] span_r;
  logic [SPAN_W-1:0] divisor;
  logic              span_zero;
  reg_idx_t          reg_sel;
  logic              cfg_wr;
  logic              chain_en;
  logic [POS_W-1:0]  position;

  logic   stg_valid [0:PROD_W];
  lanes_t stg_lanes [0:PROD_W];
  lanes_t front_nxt;

  logic [4*CH_W-1:0] push_data;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      span_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_START: start_r <= cfg_pwdata;
        REG_END:   end_r   <= cfg_pwdata;
        REG_SPAN:  span_r  <= cfg_pwdata[SPAN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START: cfg_prdata = start_r;
      REG_END:   cfg_prdata = end_r;
      REG_SPAN:  cfg_prdata = {{(32-SPAN_W){1'b0}}, span_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Saturated divisor
  assign divisor   = ({{(32-SPAN_W){1'b0}}, span_r} > 32'(MAX_SPAN)) ?
                     SPAN_W'(MAX_SPAN) : span_r;
  assign span_zero = (span_r == '0);

  // Front stage: channel difference magnitude times position
  assign position = in_tdata[POS_W-1:0];
  assign in_tready = chain_en;

  always_comb begin
    logic [CH_W-1:0] s;
    logic [CH_W-1:0] e;
    logic [CH_W-1:0] mag;
    for (int i = 0; i < LANES; i++) begin
      s   = start_r[i*CH_W +: CH_W];
      e   = end_r[i*CH_W +: CH_W];
      mag = (e >= s) ? (e - s) : (s - e);
      front_nxt[i].rem  = '0;
      front_nxt[i].num  = PROD_W'(mag * position);
      front_nxt[i].neg  = (e < s);
      front_nxt[i].base = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid[0] <= 1'b0;
    end else if (chain_en) begin
      stg_valid[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_en) begin
      stg_lanes[0] <= front_nxt;
    end
  end

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < PROD_W; k++) begin : g_cell
    lgci_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (chain_en),
      .divisor   (divisor),
      .in_valid  (stg_valid[k]),
      .in_lanes  (stg_lanes[k]),
      .out_valid (stg_valid[k+1]),
      .out_lanes (stg_lanes[k+1])
    );
  end

  // Apply the signed quotient to the start byte
  always_comb begin
    logic [CH_W-1:0] q;
    logic [CH_W-1:0] ch [LANES];
    for (int i = 0; i < LANES; i++) begin
      q     = span_zero ? '0 : stg_lanes[PROD_W][i].num[CH_W-1:0];
      ch[i] = stg_lanes[PROD_W][i].neg ? (stg_lanes[PROD_W][i].base - q)
                                       : (stg_lanes[PROD_W][i].base + q);
    end
    push_data = {ch[LANE_ALPHA], ch[LANE_BLUE], ch[LANE_GREEN], ch[LANE_RED]};
  end

  lgci_out_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (stg_valid[PROD_W]),
    .push_data  (push_data),
    .chain_en   (chain_en),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_ready  (out_tready)
  );

  // Checks
  `LGCI_ASSERT(a_zero_span_start, (out_tvalid && span_zero) |-> (out_tdata == {start_r[31:24], start_r[7:0], start_r[15:8], start_r[23:16]}), "zero span result differs from start color")
  `LGCI_ASSERT(a_stall_src, $fell(in_tready) |-> $past(out_tvalid && !out_tready), "input stalled without a result-side stall")
  `LGCI_ASSERT(a_stall_has_out, !in_tready |-> out_tvalid, "input stalled with no result pending")
  `LGCI_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_tvalid && in_tready), "pipeline not cleared by reset")

endmodule

// ===== hdl/lgci_div_cell.sv =====
// One restoring-division cell: retires one quotient bit for every lane.
module lgci_div_cell
  import lgci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [SPAN_W-1:0] divisor,
  input  logic              in_valid,
  input  lanes_t            in_lanes,
  output logic              out_valid,
  output lanes_t            out_lanes
);

  logic   valid_r;
  lanes_t lanes_r;
  lanes_t lanes_nxt;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    logic [SPAN_W:0] trial;
    logic            fits;
    lanes_nxt = in_lanes;
    for (int i = 0; i < LANES; i++) begin
      trial = {in_lanes[i].rem, in_lanes[i].num[PROD_W-1]};
      fits  = (trial >= {1'b0, divisor});
      if (fits) begin
        lanes_nxt[i].rem = SPAN_W'(trial - {1'b0, divisor});
      end else begin
        lanes_nxt[i].rem = trial[SPAN_W-1:0];
      end
      lanes_nxt[i].num = {in_lanes[i].num[PROD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule

// ===== hdl/lgci_out_skid.sv =====
// Output register with one skid entry; its full flag stalls the chain.
module lgci_out_skid
  import lgci_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  logic [4*CH_W-1:0]   push_data,
  output logic                chain_en,
  output logic                out_valid,
  output logic [4*CH_W-1:0]   out_data,
  input  logic                out_ready
);

  logic              out_v_r;
  logic              out_v_nxt;
  logic [4*CH_W-1:0] out_d_r;
  logic [4*CH_W-1:0] out_d_nxt;
  logic              skid_v_r;
  logic              skid_v_nxt;
  logic [4*CH_W-1:0] skid_d_r;
  logic [4*CH_W-1:0] skid_d_nxt;
  logic              push;

  assign chain_en = !skid_v_r;
  assign push     = push_valid && chain_en;

  // Output held while stalled; skid catches the one transfer in flight
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && !out_ready) begin
      if (push) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end else if (skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt = push;
      out_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== verif/linear_gradient_color_interpolator_tb.sv =====
// Self-checking testbench for the linear gradient color interpolator.
module linear_gradient_color_interpolator_tb
  import lgci_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPAN_CAP  = 4096;
  localparam int N_RANDOM  = 400;
  localparam int LATENCY   = 22;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // one row of the directed table
  typedef struct {
    logic [31:0] start_c;
    logic [31:0] end_c;
    logic [12:0] span;
    logic [11:0] pos;
    bit          known;
    color_t      color;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [31:0] start_reg, end_reg;
  logic [12:0] span_reg;
  color_t      color_queue[$];
  int          errors = 0;
  int          colors_seen = 0;
  bit          ready_gaps = 1'b1;
  int          cfg_sets = 0;

  linear_gradient_color_interpolator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // one channel: start + trunc((end - start) * pos / span), mod 256
  function automatic logic [7:0] blend(logic [7:0] s, logic [7:0] e,
                                       logic [11:0] pos, logic [12:0] span);
    int unsigned sp;
    int unsigned q;
    sp = (span > SPAN_CAP) ? SPAN_CAP : span;
    if (sp == 0) return s;
    if (e >= s) begin
      q = ((e - s) * pos) / sp;
      return s + q[7:0];
    end
    q = ((s - e) * pos) / sp;
    return s - q[7:0];
  endfunction

  function automatic color_t gradient_color(logic [11:0] pos);
    color_t c;
    c.red   = blend(start_reg[23:16], end_reg[23:16], pos, span_reg);
    c.green = blend(start_reg[15:8],  end_reg[15:8],  pos, span_reg);
    c.blue  = blend(start_reg[7:0],   end_reg[7:0],   pos, span_reg);
    c.alpha = blend(start_reg[31:24], end_reg[31:24], pos, span_reg);
    return c;
  endfunction

  // result side: random stalls, compare each transfer with the oldest color
  always @(posedge clk) begin
    color_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      colors_seen++;
      if (color_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected color %h", $time, got);
      end else begin
        want = color_queue.pop_front();
        if (got.red !== want.red) begin
          errors++;
          $display("%0t: red exp %h got %h", $time, want.red, got.red);
        end
        if (got.green !== want.green) begin
          errors++;
          $display("%0t: green exp %h got %h", $time, want.green, got.green);
        end
        if (got.blue !== want.blue) begin
          errors++;
          $display("%0t: blue exp %h got %h", $time, want.blue, got.blue);
        end
        if (got.alpha !== want.alpha) begin
          errors++;
          $display("%0t: alpha exp %h got %h", $time, want.alpha, got.alpha);
        end
      end
    end
    out_tready <= ready_gaps ? ($urandom_range(99) >= 34) : 1'b1;
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_W'(idx) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_START: start_reg = value;
      REG_END:   end_reg = value;
      REG_SPAN:  span_reg = value[12:0];
      default: ;
    endcase
  endtask

  // wait until every color has arrived, then let the pipeline settle
  task automatic drain();
    while (color_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_gradient(logic [31:0] s, logic [31:0] e, logic [12:0] sp);
    drain();
    if (s !== start_reg) reg_write(REG_START, s);
    if (e !== end_reg) reg_write(REG_END, e);
    if (sp !== span_reg) reg_write(REG_SPAN, {19'd0, sp});
    cfg_sets++;
  endtask

  // drive one position; gaps before it when requested
  task automatic send_position(logic [11:0] pos, bit gaps, color_t want);
    if (gaps) begin
      while ($urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, pos};
    color_queue.push_back(want);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  vec_t vecs[] = '{
    // reset state: zero span, all black
    '{32'h0, 32'h0, 13'd0, 12'd0, 1'b1, 32'h0},
    '{32'h0, 32'h0, 13'd0, 12'hFFF, 1'b1, 32'h0},
    // zero span returns start color (alpha,blue,green,red in color_t order)
    '{32'h80FF4001, 32'h12345678, 13'd0, 12'hFFF, 1'b1, 32'h800140FF},
    // position zero returns start color
    '{32'h11223344, 32'hFFEEDDCC, 13'd100, 12'd0, 1'b1, 32'h11443322},
    // position equal to span returns end color
    '{32'h11223344, 32'hFFEEDDCC, 13'd100, 12'd100, 1'b1, 32'hFFCCDDEE},
    '{32'hFF00FF00, 32'h00FF00FF, 13'd1, 12'd1, 1'b1, 32'h00FF00FF},
    // extrapolation wraps
    '{32'h00000000, 32'hFFFFFFFF, 13'd1, 12'd2, 1'b1, 32'hFEFEFEFE},
    '{32'hFFFFFFFF, 32'h00000000, 13'd1, 12'hFFF, 1'b0, 32'h0},
    // descending and ascending, truncation toward zero
    '{32'hFF80FF80, 32'h00000000, 13'd3, 12'd1, 1'b0, 32'h0},
    '{32'h00000000, 32'hFF80FF80, 13'd3, 12'd1, 1'b0, 32'h0},
    // spans at and around the cap, saturation above it, then small spans
    '{32'h00000000, 32'hFFFFFFFF, 13'd4096, 12'hFFF, 1'b0, 32'h0},
    '{32'hFFFFFFFF, 32'h00000000, 13'h1FFF, 12'hFFF, 1'b0, 32'h0},
    '{32'h0055AA0F, 32'hF0AA55FF, 13'd4097, 12'd2048, 1'b0, 32'h0},
    '{32'h0055AA0F, 32'hF0AA55FF, 13'd4095, 12'hFFF, 1'b0, 32'h0},
    '{32'hA5A5A5A5, 32'h5A5A5A5A, 13'd2, 12'd1, 1'b0, 32'h0},
    '{32'hA5A5A5A5, 32'h5A5A5A5A, 13'd2, 12'hAAA, 1'b0, 32'h0}
  };

  initial begin
    logic [11:0] pos;
    logic [12:0] sp;
    int n;
    start_reg = '0;
    end_reg = '0;
    span_reg = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (vecs[i]) begin
      set_gradient(vecs[i].start_c, vecs[i].end_c, vecs[i].span);
      send_position(vecs[i].pos, 1'b0,
                    vecs[i].known ? vecs[i].color : gradient_color(vecs[i].pos));
      stop_input();
    end

    // random phases; every fourth, from the second on, runs without any idling
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(4))
        0: sp = 13'd0;
        1: sp = 13'($urandom_range(1, 16));
        2: sp = 13'($urandom_range(4097, 8191));
        default: sp = 13'($urandom_range(1, 4096));
      endcase
      set_gradient($urandom, $urandom, sp);
      ready_gaps = (cfg_sets % 4 != 2);
      repeat ($urandom_range(20, 50)) begin
        if ($urandom_range(3) == 0 || sp == 0) pos = 12'($urandom);
        else pos = 12'($urandom_range(0, (sp > 4095) ? 4095 : sp));
        send_position(pos, ready_gaps, gradient_color(pos));
        n++;
      end
      stop_input();
    end
    ready_gaps = 1'b1;

    drain();
    $display("Covered %0d gradient settings and %0d colors,", cfg_sets, colors_seen);
    $display("including zero, saturated and extrapolated spans.");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== linear_gradient_color_interpolator.f =====
+incdir+hdl
hdl/lgci_pkg.sv
hdl/lgci_div_cell.sv
hdl/lgci_out_skid.sv
hdl/linear_gradient_color_interpolator.sv
verif/linear_gradient_color_interpolator_tb.sv
